[design/contour_points_to_quadratic_curves_core_defines.svh]
// assertion macros used by the rtl file cpqc_back.sv
`ifndef CONTOUR_POINTS_TO_QUADRATIC_CURVES_CORE_DEFINES_SVH
`define CONTOUR_POINTS_TO_QUADRATIC_CURVES_CORE_DEFINES_SVH

`ifndef SYNTH
`define CPQC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CPQC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CPQC_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CPQC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[design/cpqc_pkg.sv]
package cpqc_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;
    localparam int CURVES_MAX = 3;
    localparam int CNT_W = 2;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_EMPTY = 2'd0,
        PH_EVEN  = 2'd1,
        PH_ODD   = 2'd2
    } phase_t;

endpackage

[design/cpqc_front.sv]
module cpqc_front #(
    parameter int COORD_WIDTH = cpqc_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,  // point_x, point_y
    input  logic                                  s_tuser,  // on_flag
    input  logic                                  s_tlast,  // contour_end
    output logic                                  wr_valid,
    input  logic                                  wr_ready,
    output logic [cpqc_pkg::CURVES_MAX*6*COORD_WIDTH+cpqc_pkg::CNT_W-1:0] wr_data
);

    localparam int W = COORD_WIDTH;
    localparam int CURVE_W = 6 * W;
    localparam int NPUSH = 5;

    typedef struct packed {
        cpqc_pkg::phase_t   phase;
        logic signed [W-1:0] ax;
        logic signed [W-1:0] ay;
        logic signed [W-1:0] cx;
        logic signed [W-1:0] cy;
    } track_t;

    function automatic logic signed [W-1:0] mid(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        logic signed [W:0] s;
        logic signed [W:0] t;
        s = {a[W-1], a} + {b[W-1], b};
        t = s + {{W{1'b0}}, s[W]};
        return t[W:1];
    endfunction

    function automatic track_t push(input track_t st, input logic signed [W-1:0] x,
                                    input logic signed [W-1:0] y);
        track_t r;
        r = st;
        unique case (st.phase)
            cpqc_pkg::PH_EMPTY: begin
                r.ax = x;
                r.ay = y;
                r.phase = cpqc_pkg::PH_EVEN;
            end
            cpqc_pkg::PH_EVEN: begin
                r.cx = x;
                r.cy = y;
                r.phase = cpqc_pkg::PH_ODD;
            end
            cpqc_pkg::PH_ODD: begin
                r.ax = x;
                r.ay = y;
                r.phase = cpqc_pkg::PH_EVEN;
            end
            default: r = st;
        endcase
        return r;
    endfunction

    track_t              track_reg, track_next;
    logic signed [W-1:0] first_x_reg, first_y_reg;
    logic signed [W-1:0] prev_x_reg, prev_y_reg;
    logic                prev_on_reg;

    logic signed [W-1:0] px, py, fx, fy;
    logic                accept;
    logic                en   [NPUSH];
    logic signed [W-1:0] qx   [NPUSH];
    logic signed [W-1:0] qy   [NPUSH];
    logic [CURVE_W-1:0]  slot [cpqc_pkg::CURVES_MAX];
    logic [cpqc_pkg::CNT_W-1:0] n;
    track_t              st;

    assign px = s_tdata[W-1:0];
    assign py = s_tdata[2*W-1:W];
    assign accept = s_tvalid && wr_ready;
    assign s_tready = wr_ready;

    always_comb begin
        if (track_reg.phase == cpqc_pkg::PH_EMPTY) begin
            fx = px;
            fy = py;
        end else begin
            fx = first_x_reg;
            fy = first_y_reg;
        end

        en[0] = (track_reg.phase != cpqc_pkg::PH_EMPTY) && (s_tuser == prev_on_reg);
        qx[0] = mid(px, prev_x_reg);
        qy[0] = mid(py, prev_y_reg);
        en[1] = 1'b1;
        qx[1] = px;
        qy[1] = py;
        en[2] = s_tlast && !s_tuser;
        qx[2] = fx;
        qy[2] = fy;
        en[3] = s_tlast;
        qx[3] = mid(fx, s_tuser ? px : fx);
        qy[3] = mid(fy, s_tuser ? py : fy);
        en[4] = s_tlast;
        qx[4] = fx;
        qy[4] = fy;

        st = track_reg;
        n = '0;
        for (int k = 0; k < cpqc_pkg::CURVES_MAX; k++) begin
            slot[k] = '0;
        end
        for (int i = 0; i < NPUSH; i++) begin
            if (en[i]) begin
                if (st.phase == cpqc_pkg::PH_ODD &&
                    n < cpqc_pkg::CNT_W'(cpqc_pkg::CURVES_MAX)) begin
                    slot[n] = {qy[i], qx[i], st.cy, st.cx, st.ay, st.ax};
                    n = n + 1'b1;
                end
                st = push(st, qx[i], qy[i]);
            end
        end

        track_next = st;
        if (s_tlast) begin
            track_next.phase = cpqc_pkg::PH_EMPTY;
        end
    end

    always_comb begin
        wr_data = '0;
        wr_data[cpqc_pkg::CNT_W-1:0] = n;
        for (int k = 0; k < cpqc_pkg::CURVES_MAX; k++) begin
            wr_data[cpqc_pkg::CNT_W + k*CURVE_W +: CURVE_W] = slot[k];
        end
    end

    assign wr_valid = accept && (n != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_reg.phase <= cpqc_pkg::PH_EMPTY;
        end else if (accept) begin
            track_reg <= track_next;
            prev_x_reg <= px;
            prev_y_reg <= py;
            prev_on_reg <= s_tuser;
            first_x_reg <= fx;
            first_y_reg <= fy;
        end
    end

endmodule

[design/cpqc_queue.sv]
module cpqc_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_pop,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = cpqc_pkg::QUEUE_DEPTH;
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != FULL);
    assign rd_valid = (count_reg != '0);
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_pop && rd_valid;
    assign rd_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/cpqc_back.sv]
`include "contour_points_to_quadratic_curves_core_defines.svh"

module cpqc_back #(
    parameter int COORD_WIDTH = cpqc_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic rd_valid,
    output logic rd_pop,
    input  logic [cpqc_pkg::CURVES_MAX*6*COORD_WIDTH+cpqc_pkg::CNT_W-1:0] rd_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,  // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y
    output logic                                   m_tlast   // last_curve
);

    localparam int CURVE_W = 6 * COORD_WIDTH;
    localparam int M_TDATA_W = ((6*COORD_WIDTH+7)/8)*8;

    logic [cpqc_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [cpqc_pkg::CNT_W-1:0] rd_cnt;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]       m_tdata_reg;
    logic                       m_tlast_reg;
    logic                       load, last;
    logic [CURVE_W-1:0]         curve;

    assign rd_cnt = rd_data[cpqc_pkg::CNT_W-1:0];
    assign curve = rd_data[cpqc_pkg::CNT_W + idx_reg*CURVE_W +: CURVE_W];
    assign load = rd_valid && (!m_tvalid_reg || m_tready);
    assign last = (idx_reg == rd_cnt - 1'b1);
    assign rd_pop = load && last;

    always_comb begin
        idx_next = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            idx_next = last ? '0 : idx_reg + 1'b1;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= M_TDATA_W'(curve);
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

    `CPQC_ASSERT_IMPL(a_head_count, aclk, aresetn, rd_valid, (rd_cnt != '0) && (rd_cnt <= cpqc_pkg::CNT_W'(cpqc_pkg::CURVES_MAX)))
    `CPQC_ASSERT_IMPL(a_idx_in_entry, aclk, aresetn, rd_valid, idx_reg < rd_cnt)
    `CPQC_ASSERT_IMPL(a_partial_head, aclk, aresetn, idx_reg != '0, rd_valid)
    `CPQC_ASSERT_NEXT(a_pop_rewinds, aclk, aresetn, rd_pop, (idx_reg == '0) && m_tvalid && m_tlast)

endmodule

[design/contour_points_to_quadratic_curves_core.sv]
// channel   dir  tdata (low bit up)                          tuser      tlast
// s_        in   point_x, point_y                            on_flag    contour_end
// m_        out  start_x, start_y, ctrl_x, ctrl_y, end_x, end_y  -       last_curve
//
// a point is expanded in the cycle it is taken; it yields zero to three curves
// the output register sends one curve per cycle while m_tready is high
// a taken point's curves pass a two-entry queue and then the output register before m_tvalid rises
// s_tready drops only while the queue is full; m_tready stalls just the output side
// aresetn is synchronous: clears the contour phase, the queue and the output beat
module contour_points_to_quadratic_curves_core #(
    parameter int COORD_WIDTH = cpqc_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,  // point_x, point_y
    input  logic                                s_tuser,  // on_flag
    input  logic                                s_tlast,  // contour_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,  // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y
    output logic                                m_tlast   // last_curve
);

    localparam int ENTRY_W = cpqc_pkg::CURVES_MAX * 6 * COORD_WIDTH + cpqc_pkg::CNT_W;

    logic               wr_valid, wr_ready;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_valid, rd_pop;
    logic [ENTRY_W-1:0] rd_data;

    cpqc_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data)
    );

    cpqc_queue #(
        .DATA_W(ENTRY_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data),
        .rd_valid (rd_valid),
        .rd_pop   (rd_pop),
        .rd_data  (rd_data)
    );

    cpqc_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid),
        .rd_pop   (rd_pop),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CW         = cpqc_pkg::COORD_WIDTH_DEFAULT;
    localparam int SD_W       = ((2*CW+7)/8)*8;
    localparam int MD_W       = ((6*CW+7)/8)*8;
    localparam int CYCLE_MAX  = 200000;
    localparam int DRAIN_WAIT = 20;
    localparam int REPORT_MAX = 10;
    localparam int RANDOM_PTS = 360;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 on;
    } pt_t;

    typedef struct packed {
        pt_t  p;
        logic last;
    } point_beat_t;

    typedef struct packed {
        logic [MD_W-1:0] tdata;
        logic            last_curve;
    } curve_t;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [SD_W-1:0] s_tdata  = '0;
    logic            s_tuser  = 1'b0;
    logic            s_tlast  = 1'b0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [MD_W-1:0] m_tdata;
    logic            m_tlast;

    contour_points_to_quadratic_curves_core #(.COORD_WIDTH(CW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predicted contour state
    pt_t              first_pt, prev_pt, anchor_pt, control_pt;
    cpqc_pkg::phase_t expand_phase = cpqc_pkg::PH_EMPTY;

    point_beat_t points_to_send[$];
    curve_t      expected_curves[$];
    point_beat_t cur_point;

    int total_points   = 0;
    int total_contours = 0;
    int points_taken   = 0;
    int curves_seen    = 0;
    int curves_emitted = 0;
    int mismatches     = 0;
    int cycles         = 0;

    function automatic pt_t midpoint(pt_t a, pt_t b, logic on);
        pt_t r;
        int  sx, sy;
        sx = int'(a.x) + int'(b.x);
        sy = int'(a.y) + int'(b.y);
        r.x = CW'(sx / 2);
        r.y = CW'(sy / 2);
        r.on = on;
        return r;
    endfunction

    task automatic append_expanded(pt_t q);
        curve_t c;
        case (expand_phase)
            cpqc_pkg::PH_EMPTY: begin
                anchor_pt = q;
                expand_phase = cpqc_pkg::PH_EVEN;
            end
            cpqc_pkg::PH_EVEN: begin
                control_pt = q;
                expand_phase = cpqc_pkg::PH_ODD;
            end
            default: begin
                c.tdata = MD_W'({q.y, q.x, control_pt.y, control_pt.x,
                                 anchor_pt.y, anchor_pt.x});
                c.last_curve = 1'b0;
                expected_curves.insert(expected_curves.size(), c);
                curves_emitted++;
                anchor_pt = q;
                expand_phase = cpqc_pkg::PH_EVEN;
            end
        endcase
        prev_pt = q;
    endtask

    task automatic expand_point(point_beat_t b);
        int curves_prior;
        curves_prior = expected_curves.size();
        if (expand_phase == cpqc_pkg::PH_EMPTY) begin
            first_pt = b.p;
        end else if (b.p.on == prev_pt.on) begin
            append_expanded(midpoint(b.p, prev_pt, !b.p.on));
        end
        append_expanded(b.p);
        if (b.last) begin
            if (!b.p.on)
                append_expanded(first_pt);
            append_expanded(midpoint(first_pt, prev_pt, 1'b0));
            append_expanded(first_pt);
            expand_phase = cpqc_pkg::PH_EMPTY;
        end
        if (expected_curves.size() > curves_prior)
            expected_curves[expected_curves.size()-1].last_curve = 1'b1;
    endtask

    task automatic add_point(int x, int y, bit on, bit last);
        point_beat_t b;
        b.p.x = CW'(x);
        b.p.y = CW'(y);
        b.p.on = on;
        b.last = last;
        points_to_send.insert(points_to_send.size(), b);
        total_points++;
        if (last)
            total_contours++;
    endtask

    function automatic int pick_coord();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0: return -32768;
                    1: return 32767;
                    2: return -1;
                    3: return 0;
                    default: return 1;
                endcase
            end
            1, 2: return int'($urandom_range(0, 40)) - 20;
            default: return int'($signed(CW'($urandom)));
        endcase
    endfunction

    // driver: bursts of beats with idle gaps
    int burst_left = 0;
    int gap_left   = 0;
    bit next_valid;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                expand_point(cur_point);
                points_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (points_to_send.size() > 0) begin
                    cur_point = points_to_send.pop_front();
                    s_tdata <= SD_W'({cur_point.p.y, cur_point.p.x});
                    s_tuser <= cur_point.p.on;
                    s_tlast <= cur_point.last;
                    next_valid = 1'b1;
                    if (burst_left == 0)
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 8);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = $urandom_range(1, 7);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // receiver: own stall pattern plus two long hold-offs
    int       hold_left  = 0;
    int       holds_done = 0;
    bit [7:0] rx_tick    = '0;
    int       rx_mode    = 0;
    bit       next_ready;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_tick[5:0] == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if ((holds_done == 0 && curves_seen >= 40) ||
                         (holds_done == 1 && curves_seen >= 200)) begin
                holds_done++;
                hold_left = 300;
                next_ready = 1'b0;
            end else begin
                case (rx_mode)
                    0: next_ready = 1'b1;
                    1: next_ready = $urandom_range(0, 1);
                    2: next_ready = (rx_tick[1:0] == 2'd0);
                    default: next_ready = ($urandom_range(0, 9) != 0);
                endcase
            end
            m_tready <= next_ready;
        end
    end

    // monitor
    string  field_name[7] = '{"start_x", "start_y", "ctrl_x", "ctrl_y",
                              "end_x", "end_y", "last_curve"};
    curve_t want;
    int     want_v, got_v;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            curves_seen++;
            if (expected_curves.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected curve beat: tdata %h last %b", m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = expected_curves.pop_front();
                for (int k = 0; k < 7; k++) begin
                    if (k < 6) begin
                        want_v = int'($signed(want.tdata[k*CW +: CW]));
                        got_v  = int'($signed(m_tdata[k*CW +: CW]));
                    end else begin
                        want_v = want.last_curve;
                        got_v  = m_tlast;
                    end
                    if (want_v != got_v) begin
                        if (mismatches < REPORT_MAX)
                            $display("curve %0d %s: expected %0d, got %0d",
                                     curves_seen, field_name[k], want_v, got_v);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_MAX) begin
            $display("timeout after %0d cycles, %0d curves outstanding",
                     cycles, expected_curves.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int  len, on_mode;
        bit  on;

        // single-point contours, on and off curve
        add_point(32767, -32768, 1, 1);
        add_point(-32768, 32767, 0, 1);
        // on-on runs with negative odd sums
        add_point(0, 0, 1, 0);
        add_point(-3, -5, 1, 0);
        add_point(100, 7, 1, 1);
        // all off-curve contour
        add_point(10, 10, 0, 0);
        add_point(-11, 21, 0, 0);
        add_point(5, -5, 0, 1);
        // closing point off curve
        add_point(-32768, -32768, 1, 0);
        add_point(32767, 32767, 0, 0);
        add_point(-1, 1, 1, 0);
        add_point(-32768, 32767, 0, 1);
        // opposite extremes
        add_point(-32768, -32768, 1, 0);
        add_point(32767, 32767, 1, 1);
        // first point off curve, mixed
        add_point(1, -1, 0, 0);
        add_point(-32767, 32767, 1, 0);
        add_point(32767, -32767, 1, 0);
        add_point(0, -32768, 0, 1);
        add_point(-1, -1, 1, 0);
        add_point(-2, -2, 0, 0);
        add_point(-3, 3, 1, 1);

        while (total_points < 21 + RANDOM_PTS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 10);
            on_mode = $urandom_range(0, 2);
            for (int i = 0; i < len; i++) begin
                case (on_mode)
                    0: on = $urandom_range(0, 1);
                    1: on = ($urandom_range(0, 3) != 0);
                    default: on = ($urandom_range(0, 3) == 0);
                endcase
                add_point(pick_coord(), pick_coord(), on, i == len - 1);
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (points_taken < total_points)
            @(posedge aclk);
        while (expected_curves.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("run covered %0d points in %0d contours, %0d curves predicted, %0d received",
                 total_points, total_contours, curves_emitted, curves_seen);
        $display("receiver hold-offs: %0d, mismatching fields: %0d", holds_done, mismatches);
        if (mismatches == 0 && expected_curves.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
